[hw/rtl/u8t_pkg.sv]
// shared types, constants and the utf-8 encoder for the transcoder
package u8t_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	typedef enum logic [5:0] {
		FMT_UNDEC = 6'b000001,
		FMT_PASS  = 6'b000010,
		FMT_U16LE = 6'b000100,
		FMT_U16BE = 6'b001000,
		FMT_U32LE = 6'b010000,
		FMT_U32BE = 6'b100000
	} fmt_t;

	typedef enum logic [1:0] {
		CMD_RAW  = 2'd0,
		CMD_CP   = 2'd1,
		CMD_MARK = 2'd2
	} cmd_kind_t;

	// one step: raw bytes (first byte in [7:0]), a code point or a mark
	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] data;
		logic [2:0]  cnt;
		logic        last;
	} cmd_t;

	typedef struct packed {
		logic [31:0] bytes;
		logic [2:0]  len;
	} enc_t;

	localparam logic [31:0] LIM_1B = 32'h0000_0080;
	localparam logic [31:0] LIM_2B = 32'h0000_0800;
	localparam logic [31:0] LIM_3B = 32'h0001_0000;

	function automatic enc_t encode_cp(input logic [31:0] v);
		enc_t e;
		e = '0;
		if (v < LIM_1B) begin
			e.bytes = {24'h0, v[7:0]};
			e.len   = 3'd1;
		end else if (v < LIM_2B) begin
			e.bytes = {16'h0, 2'b10, v[5:0], 3'b110, v[10:6]};
			e.len   = 3'd2;
		end else if (v < LIM_3B) begin
			e.bytes = {8'h0, 2'b10, v[5:0], 2'b10, v[11:6], 4'hE, v[15:12]};
			e.len   = 3'd3;
		end else begin
			e.bytes = {2'b10, v[5:0], 2'b10, v[11:6], 2'b10, v[17:12],
				8'hF0 | v[25:18]};
			e.len   = 3'd4;
		end
		return e;
	endfunction

endpackage

[hw/rtl/utf16_utf32_to_utf8_transcoder_top.sv]
// top level of the utf-16/utf-32 to utf-8 transcoder with mark detection
//
// channel   direction  handshake            payload
// input     in         push / full          in_byte, in_last
// result    out        empty / pop          out_byte, out_valid, out_last
//
// one input byte per cycle while the command queue has room
// results leave at one byte per cycle from the serializer while pop is held; a code point gives 1 to 4 bytes
// a result passes through the command queue, the serializer work register and the output register
// a stalled result holds in the output register while the queue keeps taking input until it is full
// reset clears format, detection and queue state; the next byte starts a new stream
module utf16_utf32_to_utf8_transcoder_top #(
	parameter int unsigned QueueDepth = u8t_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic       out_last
);

	u8t_pkg::cmd_t wr_cmd, rd_cmd;
	logic          cmd_push, cmd_pop, cmd_avail;

	u8t_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (push && !full),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.cmd_push (cmd_push),
		.cmd      (wr_cmd)
	);

	u8t_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.wr_cmd   (wr_cmd),
		.pop      (cmd_pop),
		.rd_cmd   (rd_cmd),
		.full     (full),
		.nonempty (cmd_avail)
	);

	u8t_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (rd_cmd),
		.cmd_avail (cmd_avail),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.out_byte  (out_byte),
		.out_valid (out_valid),
		.out_last  (out_last)
	);

endmodule

[hw/rtl/u8t_front.sv]
// front end: mark detection, code unit assembly and surrogate pairing
module u8t_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	output logic          cmd_push,
	output u8t_pkg::cmd_t cmd
);

	logic [7:0]     det_q [3];
	logic [1:0]     det_cnt_q, det_cnt_nxt;
	u8t_pkg::fmt_t  fmt_q, fmt_nxt;
	logic [23:0]    unit_q, unit_nxt;
	logic [1:0]     unit_cnt_q, unit_cnt_nxt;
	logic [9:0]     lead_q, lead_nxt;
	logic           lead_vld_q, lead_vld_nxt;

	logic [7:0]     p [4];
	logic [2:0]     n;
	logic           deciding;
	logic           m32le, m32be, m16le, m16be, m8;
	logic           u16_rdy;
	logic [15:0]    u16;
	logic           cmd_vld;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p[i] = (det_cnt_q == 2'(i)) ? in_byte : det_q[i];
		end
		p[3] = in_byte;
		n = {1'b0, det_cnt_q} + 3'd1;
		deciding = (det_cnt_q == 2'd3) || in_last;
		m32le = (n == 3'd4) && p[0] == 8'hFF && p[1] == 8'hFE && p[2] == 8'h00
			&& p[3] == 8'h00;
		m32be = (n == 3'd4) && p[0] == 8'h00 && p[1] == 8'h00 && p[2] == 8'hFE
			&& p[3] == 8'hFF;
		m16le = (n >= 3'd2) && p[0] == 8'hFF && p[1] == 8'hFE;
		m16be = (n >= 3'd2) && p[0] == 8'hFE && p[1] == 8'hFF;
		m8    = (n >= 3'd3) && p[0] == 8'hEF && p[1] == 8'hBB && p[2] == 8'hBF;
	end

	always_comb begin
		det_cnt_nxt  = det_cnt_q;
		fmt_nxt      = fmt_q;
		unit_nxt     = unit_q;
		unit_cnt_nxt = unit_cnt_q;
		lead_nxt     = lead_q;
		lead_vld_nxt = lead_vld_q;
		u16_rdy      = 1'b0;
		u16          = '0;
		cmd_vld      = 1'b0;
		cmd          = '0;
		cmd.kind     = u8t_pkg::CMD_RAW;
		cmd.last     = in_last;

		case (fmt_q)
			u8t_pkg::FMT_UNDEC: begin
				if (!deciding) begin
					det_cnt_nxt = det_cnt_q + 2'd1;
				end else begin
					det_cnt_nxt = 2'd0;
					if (m32le) begin
						fmt_nxt = u8t_pkg::FMT_U32LE;
					end else if (m32be) begin
						fmt_nxt = u8t_pkg::FMT_U32BE;
					end else if (m16le || m16be) begin
						fmt_nxt = m16le ? u8t_pkg::FMT_U16LE : u8t_pkg::FMT_U16BE;
						if (n == 3'd3) begin
							unit_nxt     = {16'h0, p[2]};
							unit_cnt_nxt = 2'd1;
						end else if (n == 3'd4) begin
							u16_rdy = 1'b1;
							u16     = m16le ? {p[3], p[2]} : {p[2], p[3]};
						end
					end else if (m8) begin
						fmt_nxt = u8t_pkg::FMT_PASS;
						if (n == 3'd4) begin
							cmd_vld  = 1'b1;
							cmd.data = {24'h0, p[3]};
							cmd.cnt  = 3'd1;
						end
					end else begin
						fmt_nxt  = u8t_pkg::FMT_PASS;
						cmd_vld  = 1'b1;
						cmd.data = {p[3], p[2], p[1], p[0]};
						cmd.cnt  = n;
					end
				end
			end
			u8t_pkg::FMT_PASS: begin
				cmd_vld  = 1'b1;
				cmd.data = {24'h0, in_byte};
				cmd.cnt  = 3'd1;
			end
			u8t_pkg::FMT_U16LE, u8t_pkg::FMT_U16BE: begin
				if (unit_cnt_q == 2'd0) begin
					unit_nxt     = {16'h0, in_byte};
					unit_cnt_nxt = 2'd1;
				end else begin
					u16_rdy      = 1'b1;
					u16          = (fmt_q == u8t_pkg::FMT_U16LE) ? {in_byte, unit_q[7:0]}
						: {unit_q[7:0], in_byte};
					unit_nxt     = '0;
					unit_cnt_nxt = 2'd0;
				end
			end
			u8t_pkg::FMT_U32LE, u8t_pkg::FMT_U32BE: begin
				if (unit_cnt_q != 2'd3) begin
					unit_cnt_nxt = unit_cnt_q + 2'd1;
					if (fmt_q == u8t_pkg::FMT_U32LE) begin
						case (unit_cnt_q)
							2'd0:    unit_nxt[7:0]   = in_byte;
							2'd1:    unit_nxt[15:8]  = in_byte;
							default: unit_nxt[23:16] = in_byte;
						endcase
					end else begin
						unit_nxt = {unit_q[15:0], in_byte};
					end
				end else begin
					cmd_vld      = 1'b1;
					cmd.kind     = u8t_pkg::CMD_CP;
					cmd.data     = (fmt_q == u8t_pkg::FMT_U32LE) ? {in_byte, unit_q}
						: {unit_q, in_byte};
					unit_nxt     = '0;
					unit_cnt_nxt = 2'd0;
				end
			end
			default: begin
				fmt_nxt = u8t_pkg::FMT_UNDEC;
			end
		endcase

		// surrogate pairing
		if (u16_rdy) begin
			lead_vld_nxt = 1'b0;
			if (lead_vld_q && u16[15:10] == 6'b110111) begin
				cmd_vld  = 1'b1;
				cmd.kind = u8t_pkg::CMD_CP;
				cmd.data = 32'h0001_0000 + {12'h0, lead_q, u16[9:0]};
				lead_nxt = '0;
			end else if (u16[15:11] != 5'b11011) begin
				cmd_vld  = 1'b1;
				cmd.kind = u8t_pkg::CMD_CP;
				cmd.data = {16'h0, u16};
				lead_nxt = '0;
			end else if (u16[10] == 1'b0) begin
				lead_nxt     = u16[9:0];
				lead_vld_nxt = 1'b1;
			end else begin
				lead_nxt = '0;
			end
		end

		if (in_last) begin
			det_cnt_nxt  = 2'd0;
			fmt_nxt      = u8t_pkg::FMT_UNDEC;
			unit_nxt     = '0;
			unit_cnt_nxt = 2'd0;
			lead_nxt     = '0;
			lead_vld_nxt = 1'b0;
			if (!cmd_vld) begin
				cmd.kind = u8t_pkg::CMD_MARK;
				cmd.data = '0;
				cmd.cnt  = 3'd1;
			end
		end
		cmd_push = accept && (cmd_vld || in_last);
	end

	always_ff @(posedge clk) begin
		if (accept && fmt_q == u8t_pkg::FMT_UNDEC) begin
			for (int i = 0; i < 3; i++) begin
				if (det_cnt_q == 2'(i)) begin
					det_q[i] <= in_byte;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_cnt_q  <= 2'd0;
			fmt_q      <= u8t_pkg::FMT_UNDEC;
			unit_q     <= '0;
			unit_cnt_q <= 2'd0;
			lead_q     <= '0;
			lead_vld_q <= 1'b0;
		end else if (accept) begin
			det_cnt_q  <= det_cnt_nxt;
			fmt_q      <= fmt_nxt;
			unit_q     <= unit_nxt;
			unit_cnt_q <= unit_cnt_nxt;
			lead_q     <= lead_nxt;
			lead_vld_q <= lead_vld_nxt;
		end
	end

endmodule

[hw/rtl/u8t_queue.sv]
// command queue between front end and byte serializer
module u8t_queue #(
	parameter int unsigned Depth = u8t_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  u8t_pkg::cmd_t wr_cmd,
	input  logic          pop,
	output u8t_pkg::cmd_t rd_cmd,
	output logic          full,
	output logic          nonempty
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	u8t_pkg::cmd_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full     = (cnt_q == CntW'(Depth));
	assign nonempty = (cnt_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign rd_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/u8t_back.sv]
// back end: utf-8 encoder, output-registered serializer, 1 byte/cycle unless held
module u8t_back (
	input  logic          clk,
	input  logic          arst_n,
	input  u8t_pkg::cmd_t cmd,
	input  logic          cmd_avail,
	output logic          cmd_pop,
	input  logic          pop,
	output logic          empty,
	output logic [7:0]    out_byte,
	output logic          out_valid,
	output logic          out_last
);

	logic [31:0]   work_bytes_q;
	logic [2:0]    work_len_q;
	logic [1:0]    work_idx_q;
	logic          work_last_q;
	logic          work_dat_q;
	logic          work_busy_q;

	logic [7:0]    out_byte_q;
	logic          out_valid_q;
	logic          out_last_q;
	logic          out_full_q;

	logic          move, finish;
	u8t_pkg::enc_t enc;
	logic [7:0]    cur_byte;

	assign move     = work_busy_q && (!out_full_q || pop);
	assign finish   = move && ({1'b0, work_idx_q} == work_len_q - 3'd1);
	assign cmd_pop  = cmd_avail && (!work_busy_q || finish);
	assign cur_byte = work_bytes_q[{work_idx_q, 3'b000} +: 8];

	always_comb begin
		enc = '0;
		case (cmd.kind)
			u8t_pkg::CMD_CP: begin
				enc = u8t_pkg::encode_cp(cmd.data);
			end
			u8t_pkg::CMD_MARK: begin
				enc.bytes = '0;
				enc.len   = 3'd1;
			end
			default: begin
				enc.bytes = cmd.data;
				enc.len   = cmd.cnt;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			work_bytes_q <= enc.bytes;
			work_len_q   <= enc.len;
			work_last_q  <= cmd.last;
			work_dat_q   <= (cmd.kind != u8t_pkg::CMD_MARK);
		end
		if (move) begin
			out_byte_q  <= cur_byte;
			out_valid_q <= work_dat_q;
			out_last_q  <= work_last_q && finish;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_busy_q <= 1'b0;
			work_idx_q  <= 2'd0;
			out_full_q  <= 1'b0;
		end else begin
			if (cmd_pop) begin
				work_busy_q <= 1'b1;
				work_idx_q  <= 2'd0;
			end else if (finish) begin
				work_busy_q <= 1'b0;
			end else if (move) begin
				work_idx_q <= work_idx_q + 2'd1;
			end
			if (move) begin
				out_full_q <= 1'b1;
			end else if (pop) begin
				out_full_q <= 1'b0;
			end
		end
	end

	assign empty     = !out_full_q;
	assign out_byte  = out_byte_q;
	assign out_valid = out_valid_q;
	assign out_last  = out_last_q;

endmodule

[hw/rtl/u8t_checker.sv]
// port-level checks for the transcoder, bound to the top level
module u8t_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       out_valid,
	input logic       out_last
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> empty && !full)
		else $error("ports not idle in reset");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !out_valid |-> out_last)
		else $error("end marker without last");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !out_valid |-> out_byte == 8'h00)
		else $error("end marker carries a byte");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_byte) && $stable(out_valid)
			&& $stable(out_last))
		else $error("stalled result changed");

endmodule

bind utf16_utf32_to_utf8_transcoder_top u8t_checker u_chk (.*);

[verif/tb.sv]
// self-checking testbench for the utf-16/utf-32 to utf-8 transcoder
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam logic [15:0] LEAD_LO = 16'hD800;
	localparam logic [15:0] TRAIL_LO = 16'hDC00;
	localparam logic [15:0] SURR_END = 16'hE000;
	localparam logic [31:0] PLANE1 = 32'h0001_0000;
	localparam logic [7:0] MARK_BYTES [8] = '{8'h00, 8'hFF, 8'hFE, 8'hEF, 8'hBB, 8'hBF,
		8'hD8, 8'hDC};

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       fin;
	} utf8_res_t;

	class utf8_board;
		u8t_pkg::fmt_t fmt;
		logic [7:0]  prefix [4];
		int unsigned prefix_n;
		logic [31:0] unit_acc;
		int unsigned unit_n;
		logic [15:0] lead;
		bit          lead_ok;
		utf8_res_t   step_out[$];
		utf8_res_t   utf8_due[$];
		int          errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			fmt = u8t_pkg::FMT_UNDEC;
			prefix_n = 0;
			unit_acc = '0;
			unit_n = 0;
			lead = '0;
			lead_ok = 1'b0;
		endfunction

		function void put(logic [7:0] b, logic v);
			utf8_res_t r;
			r.data = b;
			r.valid = v;
			r.fin = 1'b0;
			step_out.push_back(r);
		endfunction

		function void put_cp(logic [31:0] c);
			if (c < 32'h80) begin
				put(c[7:0], 1'b1);
			end else if (c < 32'h800) begin
				put(8'hC0 | {3'b0, c[10:6]}, 1'b1);
				put(8'h80 | {2'b0, c[5:0]}, 1'b1);
			end else if (c < PLANE1) begin
				put(8'hE0 | {4'b0, c[15:12]}, 1'b1);
				put(8'h80 | {2'b0, c[11:6]}, 1'b1);
				put(8'h80 | {2'b0, c[5:0]}, 1'b1);
			end else begin
				put(8'hF0 | c[25:18], 1'b1);
				put(8'h80 | {2'b0, c[17:12]}, 1'b1);
				put(8'h80 | {2'b0, c[11:6]}, 1'b1);
				put(8'h80 | {2'b0, c[5:0]}, 1'b1);
			end
		endfunction

		function void take_unit16(logic [15:0] u);
			if (lead_ok) begin
				lead_ok = 1'b0;
				if (u >= TRAIL_LO && u < SURR_END) begin
					put_cp(PLANE1 + {12'h0, lead[9:0], u[9:0]});
					lead = '0;
					return;
				end
				lead = '0;
			end
			if (u < LEAD_LO || u >= SURR_END) begin
				put_cp({16'h0, u});
			end else if (u < TRAIL_LO) begin
				lead = u;
				lead_ok = 1'b1;
			end
		endfunction

		function void feed(logic [7:0] b);
			int unsigned need;
			logic [31:0] u;
			case (fmt)
				u8t_pkg::FMT_U16LE, u8t_pkg::FMT_U16BE: need = 2;
				u8t_pkg::FMT_U32LE, u8t_pkg::FMT_U32BE: need = 4;
				default: begin
					put(b, 1'b1);
					return;
				end
			endcase
			if (fmt == u8t_pkg::FMT_U16LE || fmt == u8t_pkg::FMT_U32LE)
				unit_acc = unit_acc | ({24'h0, b} << (8 * unit_n));
			else
				unit_acc = {unit_acc[23:0], b};
			unit_n++;
			if (unit_n >= need) begin
				u = unit_acc;
				unit_acc = '0;
				unit_n = 0;
				if (need == 2)
					take_unit16(u[15:0]);
				else
					put_cp(u);
			end
		endfunction

		function void decide();
			int unsigned skip;
			skip = 0;
			fmt = u8t_pkg::FMT_PASS;
			if (prefix_n >= 4 && prefix[0] == 8'hFF && prefix[1] == 8'hFE &&
					prefix[2] == 8'h00 && prefix[3] == 8'h00) begin
				fmt = u8t_pkg::FMT_U32LE;
				skip = 4;
			end else if (prefix_n >= 4 && prefix[0] == 8'h00 && prefix[1] == 8'h00 &&
					prefix[2] == 8'hFE && prefix[3] == 8'hFF) begin
				fmt = u8t_pkg::FMT_U32BE;
				skip = 4;
			end else if (prefix_n >= 2 && prefix[0] == 8'hFF && prefix[1] == 8'hFE) begin
				fmt = u8t_pkg::FMT_U16LE;
				skip = 2;
			end else if (prefix_n >= 2 && prefix[0] == 8'hFE && prefix[1] == 8'hFF) begin
				fmt = u8t_pkg::FMT_U16BE;
				skip = 2;
			end else if (prefix_n >= 3 && prefix[0] == 8'hEF && prefix[1] == 8'hBB &&
					prefix[2] == 8'hBF) begin
				skip = 3;
			end
			for (int unsigned i = skip; i < prefix_n; i++)
				feed(prefix[i]);
			prefix_n = 0;
		endfunction

		function void note_byte(logic [7:0] b, logic fin);
			utf8_res_t r;
			step_out.delete();
			if (fmt == u8t_pkg::FMT_UNDEC) begin
				prefix[prefix_n % 4] = b;
				prefix_n++;
				if (prefix_n >= 4 || fin)
					decide();
			end else begin
				feed(b);
			end
			if (fin) begin
				if (step_out.size() == 0)
					put(8'h00, 1'b0);
				r = step_out.pop_back();
				r.fin = 1'b1;
				step_out.push_back(r);
				clear();
			end
			foreach (step_out[i])
				utf8_due.push_back(step_out[i]);
		endfunction

		function void check_byte(logic [7:0] b, logic v, logic fin);
			utf8_res_t e;
			if (utf8_due.size() == 0) begin
				$display("%0t unexpected transfer: out_byte %h out_valid %b out_last %b",
					$time, b, v, fin);
				errors++;
				return;
			end
			e = utf8_due.pop_front();
			if (b !== e.data) begin
				$display("%0t out_byte mismatch: expected %h actual %h", $time, e.data, b);
				errors++;
			end
			if (v !== e.valid) begin
				$display("%0t out_valid mismatch: expected %b actual %b", $time, e.valid, v);
				errors++;
			end
			if (fin !== e.fin) begin
				$display("%0t out_last mismatch: expected %b actual %b", $time, e.fin, fin);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       out_last;

	utf8_board   sb;
	logic [7:0]  stream[$];
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned cycles = 0;

	utf16_utf32_to_utf8_transcoder_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.out_valid(out_valid),
		.out_last (out_last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_byte(out_byte, out_valid, out_last);
	end

	function automatic logic [7:0] rbyte();
		if ($urandom_range(3) == 0)
			return MARK_BYTES[$urandom_range(7)];
		return 8'($urandom_range(255));
	endfunction

	function automatic void add16(logic [15:0] u, bit le);
		if (le) begin
			stream.push_back(u[7:0]);
			stream.push_back(u[15:8]);
		end else begin
			stream.push_back(u[15:8]);
			stream.push_back(u[7:0]);
		end
	endfunction

	function automatic void add32(logic [31:0] v, bit le);
		for (int i = 0; i < 4; i++)
			stream.push_back(le ? v[8 * i +: 8] : v[8 * (3 - i) +: 8]);
	endfunction

	function automatic void add_unit16(bit le);
		logic [15:0] lo;
		logic [15:0] hi;
		lo = LEAD_LO | 16'($urandom_range(1023));
		hi = TRAIL_LO | 16'($urandom_range(1023));
		case ($urandom_range(9))
			0, 1, 2: add16(16'($urandom_range(127)), le);
			3: add16(16'($urandom_range(16'h07FF, 16'h0080)), le);
			4: begin
				if ($urandom_range(1))
					add16(16'($urandom_range(16'hD7FF, 16'h0800)), le);
				else
					add16(16'($urandom_range(16'hFFFF, 16'hE000)), le);
			end
			5, 6: begin
				add16(lo, le);
				add16(hi, le);
			end
			7: add16(lo, le);
			8: add16(hi, le);
			default: add16(16'($urandom), le);
		endcase
	endfunction

	function automatic logic [31:0] rand_u32();
		case ($urandom_range(3))
			0: return 32'($urandom_range(127));
			1: return 32'($urandom_range(32'h0000_FFFF, 32'h0000_0080));
			2: return 32'($urandom_range(32'h0010_FFFF, 32'h0001_0000));
			default: return 32'($urandom);
		endcase
	endfunction

	function automatic void build_stream();
		int unsigned kind;
		bit le;
		stream.delete();
		kind = $urandom_range(99);
		if (kind < 36) begin
			le = (kind < 18);
			add16(16'hFEFF, le);
			repeat ($urandom_range(6, 1)) add_unit16(le);
			if ($urandom_range(5) == 0)
				stream.push_back(rbyte());
		end else if (kind < 64) begin
			le = (kind < 50);
			add32(32'h0000_FEFF, le);
			repeat ($urandom_range(3, 1)) add32(rand_u32(), le);
			if ($urandom_range(5) == 0)
				repeat ($urandom_range(3, 1)) stream.push_back(rbyte());
		end else if (kind < 72) begin
			stream = '{8'hEF, 8'hBB, 8'hBF};
			repeat ($urandom_range(5)) stream.push_back(8'($urandom_range(255)));
		end else if (kind < 84) begin
			repeat ($urandom_range(8, 1)) stream.push_back(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(6, 1)) stream.push_back(rbyte());
		end
	endfunction

	task automatic send_byte(logic [7:0] b, logic fin);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		in_byte <= b;
		in_last <= fin;
		do @(posedge clk); while (full);
		sb.note_byte(b, fin);
	endtask

	task automatic send_stream();
		for (int i = 0; i < stream.size(); i++)
			send_byte(stream[i], i == stream.size() - 1);
	endtask

	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (sb.utf8_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned sent;
		sb = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed streams: utf-32 with top bits set, pairs and lone surrogates,
		// pending lead plus partial unit at end, short marks, one-byte stream
		stream = '{8'hFF, 8'hFE, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_stream();
		stream = '{8'hFE, 8'hFF, 8'hD8, 8'h3D, 8'hDE, 8'h00, 8'hDC, 8'h00,
			8'hD8, 8'h00, 8'h00, 8'h41, 8'hDB, 8'hFF, 8'h12};
		send_stream();
		stream = '{8'hFF, 8'hFE};
		send_stream();
		stream = '{8'hEF, 8'hBB, 8'hBF};
		send_stream();
		stream = '{8'h80};
		send_stream();
		drain();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 50; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 50; end
				default: begin idle_pct = 12; stall_pct = 12; end
			endcase
			sent = 0;
			while (sent < 30) begin
				build_stream();
				send_stream();
				sent += stream.size();
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.utf8_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
